### design/tau_met_transverse_mass_assert.svh
// Assertion macros shared by the transverse mass design.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef TAU_MET_TRANSVERSE_MASS_ASSERT_SVH
`define TAU_MET_TRANSVERSE_MASS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("transverse mass assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TMT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("transverse mass assertion failed");

`endif

### design/tmt_pkg.sv
// Package for the tau and missing ET transverse mass block.
// It holds the fixed field widths, the status codes and the result record; it needs nothing else.
`timescale 1ns / 1ps

package tmt_pkg;

   localparam int MASS_W   = 16;
   localparam int MT_W     = 21;
   localparam int STATUS_W = 2;

   localparam logic [MASS_W-1:0] TAU_MASS_RESET = 16'd227;
   localparam logic [MT_W-1:0]   MT_FULL_SCALE  = '1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NORMAL     = 2'd0,
      STATUS_DEGENERATE = 2'd1,
      STATUS_NEGATIVE   = 2'd2
   } status_type;

   typedef struct packed {
      logic degen;
      logic negsq;
   } flags_type;

   typedef struct packed {
      logic [MT_W-1:0] transverse_mass;
      status_type      status;
      logic            saturated;
   } rsp_data_type;

endpackage

### design/tmt_if.sv
// Channel interfaces of the transverse mass block: the tau and missing momentum request
// and the transverse mass response. Depends on tmt_pkg for the status type.
`timescale 1ns / 1ps

interface tmt_req_if #(parameter int MOMENTUM_BITS = 20) ();
   logic                            valid;
   logic                            ready;
   logic signed [MOMENTUM_BITS-1:0] tau_px;
   logic signed [MOMENTUM_BITS-1:0] tau_py;
   logic signed [MOMENTUM_BITS-1:0] tau_pz;
   logic signed [MOMENTUM_BITS-1:0] met_px;
   logic signed [MOMENTUM_BITS-1:0] met_py;

   modport source (output valid, tau_px, tau_py, tau_pz, met_px, met_py, input ready);
   modport sink   (input valid, tau_px, tau_py, tau_pz, met_px, met_py, output ready);
endinterface

interface tmt_rsp_if
   import tmt_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [MT_W-1:0]         transverse_mass;
   status_type              status;
   logic                    saturated;

   modport source (output valid, transverse_mass, status, saturated, input ready);
   modport sink   (input valid, transverse_mass, status, saturated, output ready);
endinterface

### design/tmt_isqrt.sv
// Pipelined floor integer square root, one result bit per register stage.
// Stands alone; the caller carries valid bits and side data alongside.
`timescale 1ns / 1ps

module tmt_isqrt #(
   parameter int IN_W = 44
) (
   input  logic              clock,
   input  logic              adv,
   input  logic [IN_W-1:0]   radicand,
   output logic [IN_W/2-1:0] root
);
   localparam int N = IN_W / 2;

   logic [IN_W-1:0] x_ff    [N];
   logic [N+1:0]    rem_ff  [N];
   logic [N-1:0]    root_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [IN_W-1:0] x_cur;
      logic [N+1:0]    rem_cur;
      logic [N-1:0]    root_cur;
      logic [N+3:0]    part;
      logic [N+3:0]    trial;
      logic [IN_W-1:0] x_in;
      logic [N+1:0]    rem_in;
      logic [N-1:0]    root_in;

      if (k == 0) begin : g_first
         assign x_cur    = radicand;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign x_cur    = x_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
      end

      // Bring down the next two radicand bits and try the digit one.
      always_comb begin
         part  = {rem_cur, x_cur[IN_W-1 -: 2]};
         trial = {2'b00, root_cur, 2'b01};
         x_in  = {x_cur[IN_W-3:0], 2'b00};
         if (part >= trial) begin
            rem_in  = (N+2)'(part - trial);
            root_in = {root_cur[N-2:0], 1'b1};
         end else begin
            rem_in  = part[N+1:0];
            root_in = {root_cur[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[k]    <= x_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[N-1];

endmodule

### design/tmt_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Stands alone; the caller carries valid bits and side data alongside.
`timescale 1ns / 1ps

module tmt_div #(
   parameter int NUM_W = 68,
   parameter int DEN_W = 22
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [NUM_W-1:0] quotient
);
   logic [NUM_W-1:0] aq_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_step
      logic [NUM_W-1:0] aq_cur;
      logic [DEN_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [DEN_W:0]   part;
      logic [NUM_W-1:0] aq_in;
      logic [DEN_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign aq_cur  = dividend;
         assign rem_cur = '0;
         assign den_cur = divisor;
      end else begin : g_next
         assign aq_cur  = aq_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
      end

      // The dividend shifts out at the top while quotient bits shift in below.
      always_comb begin
         part = {rem_cur, aq_cur[NUM_W-1]};
         if (part >= {1'b0, den_cur}) begin
            rem_in = DEN_W'(part - {1'b0, den_cur});
            aq_in  = {aq_cur[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = part[DEN_W-1:0];
            aq_in  = {aq_cur[NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            aq_ff[k]  <= aq_in;
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_cur;
         end
      end
   end

   assign quotient = aq_ff[NUM_W-1];

endmodule

### design/tau_met_transverse_mass.sv
// Transverse mass of a tau candidate and missing ET; top level, uses tmt_pkg, tmt_if,
// tmt_isqrt and tmt_div. Takes one transaction per cycle while the skid entry is empty;
// the pipeline depth is set mostly by the bit-per-stage square roots and divider.
// The whole pipeline stalls together only when the output skid entry is occupied.
// Synchronous reset empties the pipeline and output buffer and sets tau_mass to 227.
`timescale 1ns / 1ps
`include "tau_met_transverse_mass_assert.svh"

module tau_met_transverse_mass
   import tmt_pkg::*;
#(
   parameter int MOMENTUM_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [MASS_W-1:0] csr_wr_data,
   tmt_req_if.sink           req_chan,
   tmt_rsp_if.source         rsp_chan
);
   localparam int W      = MOMENTUM_BITS;
   localparam int SQ_W   = 2 * W;
   localparam int PT2_W  = 2 * W + 1;
   localparam int P2_W   = 2 * W + 2;
   localparam int MSQ_W  = 2 * MASS_W;
   localparam int E2_W   = ((P2_W > MSQ_W) ? P2_W : MSQ_W) + 1;
   localparam int RW     = (E2_W + 1) / 2;
   localparam int RAD_W  = 2 * RW;
   localparam int PR_W   = 2 * RW;
   localparam int LW     = 2 * RW + 1;
   localparam int LH     = (LW + 1) / 2;
   localparam int PLO_W  = RW + LH;
   localparam int PHI_W  = RW + LW - LH;
   localparam int DW     = RW + LW + 1;
   localparam int R2     = (DW + 1) / 2;
   localparam int Q_W    = 2 * R2;
   localparam int CW     = (R2 > MT_W) ? R2 : MT_W;

   logic [MASS_W-1:0] tau_mass_ff;
   logic              adv;

   // Output register plus skid entry.
   logic         rsp_valid_ff;
   logic         skid_valid_ff;
   rsp_data_type rsp_data_ff;
   rsp_data_type skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tau_mass_ff <= TAU_MASS_RESET;
      end else if (csr_wr_en) begin
         tau_mass_ff <= csr_wr_data;
      end
   end

   assign adv            = !skid_valid_ff;
   assign req_chan.ready = adv;

   // Stage 1: magnitudes and signs.
   logic              v1_ff;
   logic [W-1:0]      ax_ff, ay_ff, az_ff, amx_ff, amy_ff;
   logic              sx_ff, sy_ff, smx_ff, smy_ff;
   logic [MASS_W-1:0] mass1_ff;
   logic [W-1:0]      ax_in, ay_in, az_in, amx_in, amy_in;

   always_comb begin
      ax_in  = req_chan.tau_px[W-1] ? W'(-req_chan.tau_px) : W'(req_chan.tau_px);
      ay_in  = req_chan.tau_py[W-1] ? W'(-req_chan.tau_py) : W'(req_chan.tau_py);
      az_in  = req_chan.tau_pz[W-1] ? W'(-req_chan.tau_pz) : W'(req_chan.tau_pz);
      amx_in = req_chan.met_px[W-1] ? W'(-req_chan.met_px) : W'(req_chan.met_px);
      amy_in = req_chan.met_py[W-1] ? W'(-req_chan.met_py) : W'(req_chan.met_py);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         az_ff    <= az_in;
         amx_ff   <= amx_in;
         amy_ff   <= amy_in;
         sx_ff    <= req_chan.tau_px[W-1];
         sy_ff    <= req_chan.tau_py[W-1];
         smx_ff   <= req_chan.met_px[W-1];
         smy_ff   <= req_chan.met_py[W-1];
         mass1_ff <= tau_mass_ff;
      end
   end

   // Stage 2: squares and the dot product terms.
   logic             v2_ff;
   logic [SQ_W-1:0]  pxx2_ff, pyy2_ff, pzz2_ff, mxx2_ff, myy2_ff, tx2_ff, ty2_ff;
   logic [MSQ_W-1:0] mm2_ff;
   logic             oppx2_ff, oppy2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pxx2_ff  <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
         pyy2_ff  <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
         pzz2_ff  <= SQ_W'(az_ff) * SQ_W'(az_ff);
         mxx2_ff  <= SQ_W'(amx_ff) * SQ_W'(amx_ff);
         myy2_ff  <= SQ_W'(amy_ff) * SQ_W'(amy_ff);
         tx2_ff   <= SQ_W'(ax_ff) * SQ_W'(amx_ff);
         ty2_ff   <= SQ_W'(ay_ff) * SQ_W'(amy_ff);
         mm2_ff   <= MSQ_W'(mass1_ff) * MSQ_W'(mass1_ff);
         oppx2_ff <= sx_ff ^ smx_ff;
         oppy2_ff <= sy_ff ^ smy_ff;
      end
   end

   // Stage 3: squared magnitudes; the dot product is kept as positive and negative parts.
   logic             v3_ff;
   logic [PT2_W-1:0] pt2_3_ff, met2_3_ff, pos3_ff, neg3_ff;
   logic [SQ_W-1:0]  pzz3_ff;
   logic [MSQ_W-1:0] mm3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pt2_3_ff  <= PT2_W'(pxx2_ff) + PT2_W'(pyy2_ff);
         met2_3_ff <= PT2_W'(mxx2_ff) + PT2_W'(myy2_ff);
         pos3_ff   <= PT2_W'(oppx2_ff ? '0 : tx2_ff) + PT2_W'(oppy2_ff ? '0 : ty2_ff);
         neg3_ff   <= PT2_W'(oppx2_ff ? tx2_ff : '0) + PT2_W'(oppy2_ff ? ty2_ff : '0);
         pzz3_ff   <= pzz2_ff;
         mm3_ff    <= mm2_ff;
      end
   end

   // Stage 4: total momentum squared and the zero MET or pt check.
   logic             v4_ff;
   logic [P2_W-1:0]  p2_4_ff;
   logic [PT2_W-1:0] pt2_4_ff, met2_4_ff, pos4_ff, neg4_ff;
   logic [MSQ_W-1:0] mm4_ff;
   logic             degen4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_4_ff   <= P2_W'(pt2_3_ff) + P2_W'(pzz3_ff);
         pt2_4_ff  <= pt2_3_ff;
         met2_4_ff <= met2_3_ff;
         pos4_ff   <= pos3_ff;
         neg4_ff   <= neg3_ff;
         mm4_ff    <= mm3_ff;
         degen4_ff <= (pt2_3_ff == '0) || (met2_3_ff == '0);
      end
   end

   // Stage 5: energy squared.
   logic             v5_ff;
   logic [E2_W-1:0]  e2_5_ff;
   logic [P2_W-1:0]  p2_5_ff;
   logic [PT2_W-1:0] pt2_5_ff, met2_5_ff, pos5_ff, neg5_ff;
   logic             degen5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e2_5_ff   <= E2_W'(p2_4_ff) + E2_W'(mm4_ff);
         p2_5_ff   <= p2_4_ff;
         pt2_5_ff  <= pt2_4_ff;
         met2_5_ff <= met2_4_ff;
         pos5_ff   <= pos4_ff;
         neg5_ff   <= neg4_ff;
         degen5_ff <= degen4_ff;
      end
   end

   // Four square roots in lockstep; side data rides a delay line of equal length.
   logic [RW-1:0] pt_r, met_r, p_r, e_r;

   tmt_isqrt #(.IN_W(RAD_W)) u_sqrt_pt (
      .clock(clock), .adv(adv), .radicand(RAD_W'(pt2_5_ff)), .root(pt_r));
   tmt_isqrt #(.IN_W(RAD_W)) u_sqrt_met (
      .clock(clock), .adv(adv), .radicand(RAD_W'(met2_5_ff)), .root(met_r));
   tmt_isqrt #(.IN_W(RAD_W)) u_sqrt_p (
      .clock(clock), .adv(adv), .radicand(RAD_W'(p2_5_ff)), .root(p_r));
   tmt_isqrt #(.IN_W(RAD_W)) u_sqrt_e (
      .clock(clock), .adv(adv), .radicand(RAD_W'(e2_5_ff)), .root(e_r));

   logic             vr_ff     [RW];
   logic [PT2_W-1:0] posr_ff   [RW];
   logic [PT2_W-1:0] negr_ff   [RW];
   logic             degenr_ff [RW];

   always_ff @(posedge clock) begin
      if (adv) begin
         posr_ff[0]   <= pos5_ff;
         negr_ff[0]   <= neg5_ff;
         degenr_ff[0] <= degen5_ff;
         for (int k = 1; k < RW; k++) begin
            posr_ff[k]   <= posr_ff[k-1];
            negr_ff[k]   <= negr_ff[k-1];
            degenr_ff[k] <= degenr_ff[k-1];
         end
      end
   end

   // Stage 6: pt times MET.
   logic             v6_ff;
   logic [PR_W-1:0]  prod6_ff;
   logic [RW-1:0]    e6_ff, p6_ff;
   logic [PT2_W-1:0] pos6_ff, neg6_ff;
   logic             degen6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod6_ff  <= PR_W'(pt_r) * PR_W'(met_r);
         e6_ff     <= e_r;
         p6_ff     <= p_r;
         pos6_ff   <= posr_ff[RW-1];
         neg6_ff   <= negr_ff[RW-1];
         degen6_ff <= degenr_ff[RW-1];
      end
   end

   // Stage 7: add the negative part of the dot product.
   logic             v7_ff;
   logic [LW-1:0]    lhs7_ff;
   logic [RW-1:0]    e7_ff, p7_ff;
   logic [PT2_W-1:0] pos7_ff;
   logic             degen7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         lhs7_ff   <= LW'(prod6_ff) + LW'(neg6_ff);
         e7_ff     <= e6_ff;
         p7_ff     <= p6_ff;
         pos7_ff   <= pos6_ff;
         degen7_ff <= degen6_ff;
      end
   end

   // Stage 8: subtract the positive part; a rounding underflow is flagged.
   logic          v8_ff;
   logic [LW-1:0] num8_ff;
   logic [RW-1:0] e8_ff, p8_ff;
   flags_type     flags8_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         num8_ff         <= lhs7_ff - LW'(pos7_ff);
         e8_ff           <= e7_ff;
         p8_ff           <= p7_ff;
         flags8_ff.degen <= degen7_ff;
         flags8_ff.negsq <= LW'(pos7_ff) > lhs7_ff;
      end
   end

   // Stage 9: energy times numerator as two partial products.
   logic             v9_ff;
   logic [PLO_W-1:0] pplo9_ff;
   logic [PHI_W-1:0] pphi9_ff;
   logic [RW-1:0]    p9_ff;
   flags_type        flags9_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pplo9_ff  <= PLO_W'(e8_ff) * PLO_W'(num8_ff[LH-1:0]);
         pphi9_ff  <= PHI_W'(e8_ff) * PHI_W'(num8_ff[LW-1:LH]);
         p9_ff     <= p8_ff;
         flags9_ff <= flags8_ff;
      end
   end

   // Stage 10: combine partial products and double.
   logic          v10_ff;
   logic [DW-1:0] dvd10_ff;
   logic [RW-1:0] p10_ff;
   flags_type     flags10_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dvd10_ff   <= ((DW'(pphi9_ff) << LH) + DW'(pplo9_ff)) << 1;
         p10_ff     <= p9_ff;
         flags10_ff <= flags9_ff;
      end
   end

   // Divide by p, then the final square root.
   logic [DW-1:0] quo;
   logic [R2-1:0] mt_r;

   tmt_div #(.NUM_W(DW), .DEN_W(RW)) u_div (
      .clock(clock), .adv(adv), .dividend(dvd10_ff), .divisor(p10_ff), .quotient(quo));

   tmt_isqrt #(.IN_W(Q_W)) u_sqrt_mt (
      .clock(clock), .adv(adv), .radicand(Q_W'(quo)), .root(mt_r));

   logic      vd_ff     [DW];
   flags_type flagsd_ff [DW];
   logic      vm_ff     [R2];
   flags_type flagsm_ff [R2];

   always_ff @(posedge clock) begin
      if (adv) begin
         flagsd_ff[0] <= flags10_ff;
         for (int k = 1; k < DW; k++) begin
            flagsd_ff[k] <= flagsd_ff[k-1];
         end
         flagsm_ff[0] <= flagsd_ff[DW-1];
         for (int k = 1; k < R2; k++) begin
            flagsm_ff[k] <= flagsm_ff[k-1];
         end
      end
   end

   // Valid bits for every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         for (int k = 0; k < RW; k++) begin
            vr_ff[k] <= 1'b0;
         end
         for (int k = 0; k < DW; k++) begin
            vd_ff[k] <= 1'b0;
         end
         for (int k = 0; k < R2; k++) begin
            vm_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff    <= req_chan.valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         vr_ff[0] <= v5_ff;
         for (int k = 1; k < RW; k++) begin
            vr_ff[k] <= vr_ff[k-1];
         end
         v6_ff    <= vr_ff[RW-1];
         v7_ff    <= v6_ff;
         v8_ff    <= v7_ff;
         v9_ff    <= v8_ff;
         v10_ff   <= v9_ff;
         vd_ff[0] <= v10_ff;
         for (int k = 1; k < DW; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
         vm_ff[0] <= vd_ff[DW-1];
         for (int k = 1; k < R2; k++) begin
            vm_ff[k] <= vm_ff[k-1];
         end
      end
   end

   // Final selection of the result record.
   logic         last_valid;
   flags_type    last_flags;
   logic [CW-1:0] mt_wide;
   rsp_data_type result;

   assign last_valid = vm_ff[R2-1];
   assign last_flags = flagsm_ff[R2-1];
   assign mt_wide    = CW'(mt_r);

   always_comb begin
      result.transverse_mass = '0;
      result.status          = STATUS_NORMAL;
      result.saturated       = 1'b0;
      if (last_flags.degen) begin
         result.status = STATUS_DEGENERATE;
      end else if (last_flags.negsq) begin
         result.status = STATUS_NEGATIVE;
      end else if (mt_wide > CW'(MT_FULL_SCALE)) begin
         result.transverse_mass = MT_FULL_SCALE;
         result.saturated       = 1'b1;
      end else begin
         result.transverse_mass = MT_W'(mt_wide);
      end
   end

   // A transaction arriving while the output register is held goes to the skid entry,
   // which in turn stalls the pipeline until the output is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && rsp_chan.ready) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= adv && last_valid;
         end
      end else if (!rsp_valid_ff) begin
         rsp_valid_ff <= adv && last_valid;
      end else if (adv && last_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && rsp_chan.ready && skid_valid_ff) begin
         rsp_data_ff <= skid_data_ff;
      end else if (!rsp_valid_ff || rsp_chan.ready) begin
         rsp_data_ff <= result;
      end
      if (rsp_valid_ff && !rsp_chan.ready && !skid_valid_ff) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.transverse_mass = rsp_data_ff.transverse_mass;
   assign rsp_chan.status          = rsp_data_ff.status;
   assign rsp_chan.saturated       = rsp_data_ff.saturated;

   `TMT_ASSERT_NOW(a_skid_behind_head, skid_valid_ff, rsp_valid_ff)
   `TMT_ASSERT_NEXT(a_stall_fills_skid, rsp_valid_ff && !rsp_chan.ready && !skid_valid_ff && last_valid, skid_valid_ff)
   `TMT_ASSERT_NOW(a_special_is_zero, rsp_valid_ff && (rsp_data_ff.status != STATUS_NORMAL), (rsp_data_ff.transverse_mass == '0) && !rsp_data_ff.saturated)
   `TMT_ASSERT_NOW(a_sat_full_scale, rsp_valid_ff && rsp_data_ff.saturated, (rsp_data_ff.transverse_mass == MT_FULL_SCALE) && (rsp_data_ff.status == STATUS_NORMAL))

endmodule

### test/tau_met_transverse_mass_tb.sv
// Self-checking testbench for tau_met_transverse_mass: directed table plus random traffic,
// with each response checked against a table value or an integer transverse mass calculation in this file.
// Depends on tmt_pkg, the tmt_req_if and tmt_rsp_if interfaces and the design top level.
`timescale 1ns / 1ps

module tau_met_transverse_mass_tb;
   import tmt_pkg::*;

   localparam int MB = 20;
   localparam int RANDOM_ITEMS = 1250;
   localparam int DRAIN_CYCLES = 300;

   typedef logic signed [MB-1:0] mom_type;

   typedef struct {
      mom_type         px, py, pz, mx, my;
      bit              known;
      logic [MT_W-1:0] mt;
      status_type      st;
      logic            sat;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [MASS_W-1:0] csr_wr_data = '0;
   logic [MASS_W-1:0] tau_mass_cfg = TAU_MASS_RESET;

   tmt_req_if #(.MOMENTUM_BITS(MB)) req_chan ();
   tmt_rsp_if rsp_chan ();

   tau_met_transverse_mass #(.MOMENTUM_BITS(MB)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   rsp_data_type mt_expected_q[$];
   int error_count = 0;
   int rsp_count = 0;
   int degen_count = 0;
   int negsq_count = 0;
   int sent_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("tau_met_transverse_mass verification failed");
      $finish;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned root = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= root + b) begin
            x -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic rsp_data_type calc_transverse_mass(input mom_type px, py, pz, mx, my,
                                                         input logic [MASS_W-1:0] mass);
      longint sx = px, sy = py, sz = pz, smx = mx, smy = my;
      longint unsigned ax, ay, az, amx, amy, pt2, met2, p2, pt, met, p, e;
      longint unsigned pos, neg, lhs, num, mt2, mt;
      rsp_data_type r;
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      az = (sz < 0) ? -sz : sz;
      amx = (smx < 0) ? -smx : smx;
      amy = (smy < 0) ? -smy : smy;
      r.transverse_mass = '0;
      r.saturated = 1'b0;
      r.status = STATUS_NORMAL;
      pt2 = ax * ax + ay * ay;
      met2 = amx * amx + amy * amy;
      if (pt2 == 0 || met2 == 0) begin
         r.status = STATUS_DEGENERATE;
         return r;
      end
      p2 = pt2 + az * az;
      pt = int_sqrt(pt2);
      met = int_sqrt(met2);
      p = int_sqrt(p2);
      e = int_sqrt(p2 + longint'(mass) * longint'(mass));
      // The dot product is kept as separate positive and negative parts so nothing wraps.
      pos = 0;
      neg = 0;
      if ((sx < 0) != (smx < 0)) neg += ax * amx; else pos += ax * amx;
      if ((sy < 0) != (smy < 0)) neg += ay * amy; else pos += ay * amy;
      lhs = pt * met + neg;
      if (pos > lhs) begin
         r.status = STATUS_NEGATIVE;
         return r;
      end
      num = lhs - pos;
      mt2 = (2 * e * num) / p;
      mt = int_sqrt(mt2);
      if (mt > MT_FULL_SCALE) begin
         mt = MT_FULL_SCALE;
         r.saturated = 1'b1;
      end
      r.transverse_mass = mt[MT_W-1:0];
      return r;
   endfunction

   // Sends one transaction and records what it must produce once it is accepted.
   task automatic send_item(input mom_type px, py, pz, mx, my, input bit known,
                            input rsp_data_type typed);
      rsp_data_type exp_item;
      req_chan.valid <= 1'b1;
      req_chan.tau_px <= px;
      req_chan.tau_py <= py;
      req_chan.tau_pz <= pz;
      req_chan.met_px <= mx;
      req_chan.met_py <= my;
      do @(posedge clock); while (!req_chan.ready);
      exp_item = known ? typed : calc_transverse_mass(px, py, pz, mx, my, tau_mass_cfg);
      mt_expected_q.insert(mt_expected_q.size(), exp_item);
      sent_count++;
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles == 0) return;
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_tau_mass(input logic [MASS_W-1:0] mass);
      wait (mt_expected_q.size() == 0);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mass;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tau_mass_cfg = mass;
   endtask

   task automatic random_phase(input int count);
      mom_type px, py, pz, mx, my;
      rsp_data_type none;
      int burst;
      int mode;
      none = '0;
      burst = $urandom_range(1, 40);
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         px = mom_type'($urandom); py = mom_type'($urandom); pz = mom_type'($urandom);
         mx = mom_type'($urandom); my = mom_type'($urandom);
         if (mode >= 6 && mode <= 7) begin
            // Small momenta make the floor square roots round against the dot product.
            px = mom_type'($signed($urandom_range(0, 16)) - 8);
            py = mom_type'($signed($urandom_range(0, 16)) - 8);
            mx = mom_type'($signed($urandom_range(0, 16)) - 8);
            my = mom_type'($signed($urandom_range(0, 16)) - 8);
         end else if (mode == 8) begin
            px = mom_type'($signed($urandom_range(0, 2000)) - 1000);
            py = mom_type'($signed($urandom_range(0, 2000)) - 1000);
            mx = px;
            my = py;
         end else if (mode == 9) begin
            if ($urandom_range(0, 1)) begin
               px = '0; py = '0;
            end else begin
               mx = '0; my = '0;
            end
         end
         send_item(px, py, pz, mx, my, 1'b0, none);
         if (--burst == 0 && i < count - 1) begin
            burst = $urandom_range(1, 40);
            pause_sender($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(0, 30));
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   // Receiver stalls follow a mode that is redrawn at random from a free-running tick counter.
   int stall_mode = 0;
   int stall_tick = 0;
   always @(posedge clock) begin
      rsp_data_type exp_rsp;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick % 256 == 255) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= (stall_tick % 3) != 0;
            2: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: rsp_chan.ready <= (stall_tick % 16) < 3;
         endcase
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_count++;
            if (mt_expected_q.size() == 0) begin
               $error("response with no transaction outstanding");
               error_count++;
            end else begin
               exp_rsp = mt_expected_q.pop_front();
               if (rsp_chan.status == STATUS_DEGENERATE) degen_count++;
               if (rsp_chan.status == STATUS_NEGATIVE) negsq_count++;
               if (rsp_chan.transverse_mass !== exp_rsp.transverse_mass) begin
                  $error("transverse_mass expected %0d actual %0d",
                         exp_rsp.transverse_mass, rsp_chan.transverse_mass);
                  error_count++;
               end
               if (rsp_chan.status !== exp_rsp.status) begin
                  $error("status expected %0d actual %0d", exp_rsp.status, rsp_chan.status);
                  error_count++;
               end
               if (rsp_chan.saturated !== exp_rsp.saturated) begin
                  $error("saturated expected %0d actual %0d",
                         exp_rsp.saturated, rsp_chan.saturated);
                  error_count++;
               end
            end
         end
      end
   end

   stim_row_type stim_table[] = '{
      // Zero tau pt and zero missing momentum are both degenerate.
      '{20'sd0, 20'sd0, 20'sd5000, 20'sd100, 20'sd100, 1'b1, 21'd0, STATUS_DEGENERATE, 1'b0},
      '{20'sd100, 20'sd100, 20'sd0, 20'sd0, 20'sd0, 1'b1, 21'd0, STATUS_DEGENERATE, 1'b0},
      '{20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b1, 21'd0, STATUS_DEGENERATE, 1'b0},
      // Collinear small vectors where rounding makes the square negative.
      '{20'sd3, 20'sd3, 20'sd0, 20'sd3, 20'sd3, 1'b1, 21'd0, STATUS_NEGATIVE, 1'b0},
      '{-20'sd3, -20'sd3, 20'sd7, -20'sd3, -20'sd3, 1'b1, 21'd0, STATUS_NEGATIVE, 1'b0},
      // Exactly parallel unit vectors give zero mass with normal status.
      '{20'sd1, 20'sd0, 20'sd0, 20'sd1, 20'sd0, 1'b1, 21'd0, STATUS_NORMAL, 1'b0},
      '{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 20'sh80000, 1'b0, '0, STATUS_NORMAL,
        1'b0},
      '{20'sh80000, 20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF, 1'b0, '0, STATUS_NORMAL,
        1'b0},
      '{20'sh80000, 20'sh0, 20'sh0, 20'sh7FFFF, 20'sh0, 1'b0, '0, STATUS_NORMAL, 1'b0},
      '{20'sh7FFFF, 20'sh80000, 20'sh0, 20'sh7FFFF, 20'sh80000, 1'b0, '0, STATUS_NORMAL, 1'b0},
      '{20'sd0, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sd0, 1'b0, '0, STATUS_NORMAL, 1'b0},
      '{20'sd1, 20'sd0, 20'sh7FFFF, -20'sd1, 20'sd0, 1'b0, '0, STATUS_NORMAL, 1'b0},
      '{-20'sd1, -20'sd1, -20'sd1, 20'sd1, -20'sd1, 1'b0, '0, STATUS_NORMAL, 1'b0},
      '{20'sd12800, -20'sd6400, 20'sd25600, -20'sd3840, 20'sd5120, 1'b0, '0, STATUS_NORMAL,
        1'b0},
      '{20'sh55555, 20'shAAAAA, 20'sh55555, 20'shAAAAA, 20'sh55555, 1'b0, '0, STATUS_NORMAL,
        1'b0}
   };

   initial begin
      rsp_data_type typed;
      logic [MASS_W-1:0] phase_mass[4];
      req_chan.valid = 1'b0;
      req_chan.tau_px = '0;
      req_chan.tau_py = '0;
      req_chan.tau_pz = '0;
      req_chan.met_px = '0;
      req_chan.met_py = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The table runs first with the mass left at its reset value.
      foreach (stim_table[i]) begin
         typed.transverse_mass = stim_table[i].mt;
         typed.status = stim_table[i].st;
         typed.saturated = stim_table[i].sat;
         send_item(stim_table[i].px, stim_table[i].py, stim_table[i].pz,
                   stim_table[i].mx, stim_table[i].my, stim_table[i].known, typed);
         if (i % 4 == 3) pause_sender($urandom_range(0, 3));
      end
      random_phase(RANDOM_ITEMS / 5);

      phase_mass[0] = 16'hFFFF;
      phase_mass[1] = 16'h0000;
      phase_mass[2] = MASS_W'($urandom);
      phase_mass[3] = TAU_MASS_RESET;
      foreach (phase_mass[k]) begin
         write_tau_mass(phase_mass[k]);
         random_phase(RANDOM_ITEMS / 10);
         // Let the pipeline drain completely before resuming the same phase.
         wait (mt_expected_q.size() == 0);
         @(posedge clock);
         random_phase(RANDOM_ITEMS / 10);
      end

      wait (mt_expected_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d transactions over five tau mass settings; %0d responses checked.",
               sent_count, rsp_count);
      $display("Responses with zero pt or MET: %0d, with negative square: %0d.",
               degen_count, negsq_count);
      if (error_count == 0 && mt_expected_q.size() == 0) begin
         $display("tau_met_transverse_mass verification clean");
      end else begin
         $display("tau_met_transverse_mass verification failed");
      end
      $finish;
   end

endmodule
